@@ hw/rtl/bqte_pkg.sv @@
package bqte_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int MAX_BITS_DEF = 32;
    localparam int PREC_W       = 6;
    localparam int OFFSET_W     = 15;
    localparam int TOKEN_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DW       = (VALUE_WIDTH > TOKEN_W) ? VALUE_WIDTH : TOKEN_W;
    localparam int ACC_W        = VALUE_WIDTH + 3;
    localparam logic [PREC_W-1:0] PREC_RESET = 6'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOADED   = 3'd4;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          value_is_nan;
    } t_request;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic               token_valid;
        logic               not_fitted;
        logic               last;
    } t_result;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] min_value;
        logic signed [VALUE_WIDTH-1:0] max_value;
        logic [PREC_W-1:0]             precision_bits;
        logic [OFFSET_W-1:0]           token_offset;
        logic                          range_loaded;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NAN,
        S_CMP_HI,
        S_CMP_LO,
        S_SPAN,
        S_INIT,
        S_STEP,
        S_DONE
    } t_state;

    function automatic logic [TOKEN_W-1:0] make_token(input logic [OFFSET_W-1:0] offset,
                                                      input logic [TOKEN_W-1:0] pos);
        make_token = {{(TOKEN_W-OFFSET_W){1'b0}}, offset} + TOKEN_W'(2) + pos;
    endfunction

endpackage

@@ hw/rtl/bisection_quantizer_token_encoder.sv @@
// Channel    Direction  Handshake                 Payload
// request    in         start high, busy low      i_request (value, value_is_nan)
// result     out        o_strobe, one cycle       o_result (token, token_valid, not_fitted, last)
// config     in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// While busy is high, an in-range request passes CMP_HI, CMP_LO, SPAN, INIT, one STEP per
// precision bit (capped at MAX_BITS) and DONE; the special paths reach DONE sooner.
// The shared adder does one bound compare, setup step or bisection step per cycle.
// A found token is held pending until the next token or DONE, so the last flag is known when it is shown.
// Synchronous active-low reset clears the sequencer and restores register defaults.
// Results cannot be stalled; busy stays high until the final result is registered.
module bisection_quantizer_token_encoder #(
    parameter int MAX_BITS = bqte_pkg::MAX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bqte_pkg::t_request             i_request,
    output logic                           o_strobe,
    output bqte_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bqte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bqte_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int W   = bqte_pkg::VALUE_WIDTH;
    localparam int EW  = bqte_pkg::ACC_W;
    localparam int TW  = bqte_pkg::TOKEN_W;
    localparam int CW  = $clog2(MAX_BITS + 1);
    localparam int PW  = $clog2(MAX_BITS + 2);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BITS);

    bqte_pkg::t_cfg    w_cfg;
    bqte_pkg::t_state  r_state, n_state;
    bqte_pkg::t_result r_out, n_out;
    logic              r_strobe, n_strobe;
    logic              r_pend_valid, n_pend_valid;
    logic [PW-1:0]     r_pend_pos, n_pend_pos;
    logic [PW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic signed [W-1:0]  r_v, n_v;
    logic signed [EW-1:0] r_e, n_e;
    logic signed [EW-1:0] r_span, n_span;

    logic signed [EW-1:0] w_a, w_b, w_sum;
    logic              w_sub, w_neg, w_zero;
    logic              w_emit;
    logic [PW-1:0]     w_emit_pos;
    logic [CW-1:0]     w_nsteps;
    logic [TW-1:0]     w_pend_ext;
    logic signed [EW-1:0] w_v_ext, w_lo_ext, w_hi_ext, w_e2;
    logic              w_bit;

    bqte_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bqte_alu #(.W(EW)) u_alu (
        .i_a    (w_a),
        .i_b    (w_b),
        .i_sub  (w_sub),
        .o_sum  (w_sum),
        .o_neg  (w_neg),
        .o_zero (w_zero)
    );

    assign w_v_ext    = {{(EW-W){r_v[W-1]}}, r_v};
    assign w_lo_ext   = {{(EW-W){w_cfg.min_value[W-1]}}, w_cfg.min_value};
    assign w_hi_ext   = {{(EW-W){w_cfg.max_value[W-1]}}, w_cfg.max_value};
    assign w_e2       = {r_e[EW-2:0], 1'b0};
    assign w_bit      = !r_e[EW-1] && (r_e != '0);
    assign w_nsteps   = (int'(w_cfg.precision_bits) > MAX_BITS) ? MAXB
                                                                : CW'(w_cfg.precision_bits);
    assign w_pend_ext = {{(TW-PW){1'b0}}, r_pend_pos};

    assign busy     = (r_state != bqte_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bqte_pkg::S_IDLE;
            r_strobe     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_strobe     <= n_strobe;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pend_pos <= n_pend_pos;
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_v        <= n_v;
        r_e        <= n_e;
        r_span     <= n_span;
    end

    always_comb begin
        n_state      = r_state;
        n_out        = r_out;
        n_strobe     = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_v          = r_v;
        n_e          = r_e;
        n_span       = r_span;
        w_a          = w_hi_ext;
        w_b          = w_v_ext;
        w_sub        = 1'b1;
        w_emit       = 1'b0;
        w_emit_pos   = '0;

        case (r_state)
            bqte_pkg::S_IDLE: begin
                if (start) begin
                    n_v          = i_request.value;
                    n_pend_valid = 1'b0;
                    if (!w_cfg.range_loaded) begin
                        n_state = bqte_pkg::S_DONE;
                    end else if (i_request.value_is_nan) begin
                        w_emit     = 1'b1;
                        w_emit_pos = PW'(0);
                        n_state    = bqte_pkg::S_NAN;
                    end else begin
                        n_state = bqte_pkg::S_CMP_HI;
                    end
                end
            end
            bqte_pkg::S_NAN: begin
                w_emit     = 1'b1;
                w_emit_pos = PW'(1);
                n_state    = bqte_pkg::S_DONE;
            end
            bqte_pkg::S_CMP_HI: begin
                w_a = w_hi_ext;
                w_b = w_v_ext;
                if (w_neg) begin
                    w_emit     = 1'b1;
                    w_emit_pos = PW'(1);
                    n_state    = bqte_pkg::S_DONE;
                end else begin
                    n_state = bqte_pkg::S_CMP_LO;
                end
            end
            bqte_pkg::S_CMP_LO: begin
                w_a = w_v_ext;
                w_b = w_lo_ext;
                n_e = w_sum;
                if (w_neg || w_zero) begin
                    w_emit     = 1'b1;
                    w_emit_pos = PW'(0);
                    n_state    = bqte_pkg::S_DONE;
                end else begin
                    n_state = bqte_pkg::S_SPAN;
                end
            end
            bqte_pkg::S_SPAN: begin
                w_a     = w_hi_ext;
                w_b     = w_lo_ext;
                n_span  = w_sum;
                n_state = bqte_pkg::S_INIT;
            end
            bqte_pkg::S_INIT: begin
                w_a   = w_e2;
                w_b   = r_span;
                n_e   = w_sum;
                n_cnt = w_nsteps;
                n_pos = PW'(2);
                if (w_nsteps == '0) begin
                    n_state = bqte_pkg::S_DONE;
                end else begin
                    n_state = bqte_pkg::S_STEP;
                end
            end
            bqte_pkg::S_STEP: begin
                w_a        = w_e2;
                w_b        = r_span;
                w_sub      = w_bit;
                n_e        = w_sum;
                w_emit     = w_bit;
                w_emit_pos = r_pos;
                n_pos      = r_pos + PW'(1);
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = bqte_pkg::S_DONE;
                end
            end
            bqte_pkg::S_DONE: begin
                n_strobe = 1'b1;
                if (r_pend_valid) begin
                    n_out.token       = bqte_pkg::make_token(w_cfg.token_offset, w_pend_ext);
                    n_out.token_valid = 1'b1;
                    n_out.not_fitted  = 1'b0;
                end else begin
                    n_out.token       = '0;
                    n_out.token_valid = 1'b0;
                    n_out.not_fitted  = !w_cfg.range_loaded;
                end
                n_out.last   = 1'b1;
                n_pend_valid = 1'b0;
                n_state      = bqte_pkg::S_IDLE;
            end
            default: begin
                n_state = bqte_pkg::S_IDLE;
            end
        endcase

        if (w_emit) begin
            if (r_pend_valid) begin
                n_strobe          = 1'b1;
                n_out.token       = bqte_pkg::make_token(w_cfg.token_offset, w_pend_ext);
                n_out.token_valid = 1'b1;
                n_out.not_fitted  = 1'b0;
                n_out.last        = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_pos   = w_emit_pos;
        end
    end

    a_done_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bqte_pkg::S_DONE) |=> (r_strobe && r_out.last))
        else $error("final result missing after done state");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.token_valid) |-> (r_out.last && (r_out.token == '0)))
        else $error("empty result not marked last");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bqte_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("pending token left behind in idle");

endmodule

@@ hw/rtl/bqte_cfg.sv @@
module bqte_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bqte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bqte_pkg::CFG_DW-1:0]       i_cfg_data,
    output bqte_pkg::t_cfg                    o_cfg
);

    bqte_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value      <= '0;
            r_cfg.max_value      <= '0;
            r_cfg.precision_bits <= bqte_pkg::PREC_RESET;
            r_cfg.token_offset   <= '0;
            r_cfg.range_loaded   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bqte_pkg::CFG_MIN_VALUE: begin
                    r_cfg.min_value <= i_cfg_data[bqte_pkg::VALUE_WIDTH-1:0];
                end
                bqte_pkg::CFG_MAX_VALUE: begin
                    r_cfg.max_value <= i_cfg_data[bqte_pkg::VALUE_WIDTH-1:0];
                end
                bqte_pkg::CFG_PRECISION_BITS: begin
                    r_cfg.precision_bits <= i_cfg_data[bqte_pkg::PREC_W-1:0];
                end
                bqte_pkg::CFG_TOKEN_OFFSET: begin
                    r_cfg.token_offset <= i_cfg_data[bqte_pkg::OFFSET_W-1:0];
                end
                bqte_pkg::CFG_RANGE_LOADED: begin
                    r_cfg.range_loaded <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/bqte_alu.sv @@
module bqte_alu #(
    parameter int W = bqte_pkg::ACC_W
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic                i_sub,
    output logic signed [W-1:0] o_sum,
    output logic                o_neg,
    output logic                o_zero
);

    assign o_sum  = i_sub ? (i_a - i_b) : (i_a + i_b);
    assign o_neg  = o_sum[W-1];
    assign o_zero = (o_sum == '0);

endmodule
